@@ src/a2h_pkg.sv @@
// ----------------------------------------------------------------------------
// a2h_pkg
// Shared types, constants and the arctangent table for the heading unit.
// ----------------------------------------------------------------------------
`default_nettype none

package a2h_pkg;

  localparam int IN_W       = 16;            // sensor component width
  localparam int ITERATIONS = 16;            // cordic micro-rotations
  localparam int TABLE_LEN  = 32;
  localparam int SH_W       = $clog2(TABLE_LEN);
  localparam int SCALE_SH   = 40 - IN_W;     // components scaled by 2^(40-IN_W)
  localparam int XY_W       = 44;            // holds 2^39 times the cordic gain
  localparam int Z_W        = 27;            // angle in 2^-16 degree, signed
  localparam int ANG_W      = 16;            // result width

  localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * 65536);
  localparam logic signed [Z_W-1:0] Z_FULL_TURN = Z_W'(360 * 65536);
  localparam logic [ANG_W:0]        OUT_TURN    = (ANG_W+1)'(360 * 128);
  localparam logic [ANG_W-1:0]      ANG_0       = ANG_W'(0);
  localparam logic [ANG_W-1:0]      ANG_90      = ANG_W'(90 * 128);
  localparam logic [ANG_W-1:0]      ANG_180     = ANG_W'(180 * 128);
  localparam logic [ANG_W-1:0]      ANG_270     = ANG_W'(270 * 128);

  // payload carried from stage to stage
  typedef struct packed {
    logic                    special;     // answer known up front
    logic [ANG_W-1:0]        spec_angle;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } stage_t;

  // atan(2^-i) in degrees, units of 2^-16
  function automatic logic signed [Z_W-1:0] atan_tab(input logic [SH_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      5'd20:   v = Z_W'(4);
      5'd21:   v = Z_W'(2);
      5'd22:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/a2h_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// a2h_cordic_stage
// One registered cordic vectoring micro-rotation with its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module a2h_cordic_stage (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [a2h_pkg::SH_W-1:0] shift,
  input  wire logic                   valid_in,
  input  wire a2h_pkg::stage_t        data_in,
  output logic                        valid_r,
  output a2h_pkg::stage_t             data_r
);

  a2h_pkg::stage_t data_nxt;
  logic signed [a2h_pkg::XY_W-1:0] xs;
  logic signed [a2h_pkg::XY_W-1:0] ys;
  logic signed [a2h_pkg::Z_W-1:0]  ang;

  always_comb begin
    xs       = data_in.x >>> shift;
    ys       = data_in.y >>> shift;
    ang      = a2h_pkg::atan_tab(shift);
    data_nxt = data_in;
    // rotate toward the x axis
    if (!data_in.y[a2h_pkg::XY_W-1]) begin
      data_nxt.x = data_in.x + ys;
      data_nxt.y = data_in.y - xs;
      data_nxt.z = data_in.z + ang;
    end else begin
      data_nxt.x = data_in.x - ys;
      data_nxt.y = data_in.y + xs;
      data_nxt.z = data_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/atan2_heading_degrees.sv @@
// ----------------------------------------------------------------------------
// atan2_heading_degrees
// Four-quadrant arctangent of a (y, x) sensor pair, in 1/128 degree units.
// ----------------------------------------------------------------------------
// Takes one request per cycle and returns atan2(y, x) folded into 0..360
// degrees, in units of 1/128 degree (0..46079), one result per request in
// order. The path runs through one input stage, one stage per cordic
// micro-rotation (16 of them), and one fold-and-round output register. The
// whole pipeline advances together whenever the output is empty or taken,
// so throughput is one pair per cycle while out_tready stays high.
// Axis-aligned inputs (x or y zero) bypass the rotation and give exact
// multiples of 90 degrees.
`default_nettype none

module atan2_heading_degrees (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] y_value, [31:16] x_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [15:0] angle_deg
);

  localparam int N = a2h_pkg::ITERATIONS;

  logic            en;
  logic            s_valid [0:N];
  a2h_pkg::stage_t s_data  [0:N];

  logic signed [a2h_pkg::IN_W-1:0] y_in;
  logic signed [a2h_pkg::IN_W-1:0] x_in;
  logic signed [a2h_pkg::IN_W:0]   y_f;
  logic signed [a2h_pkg::IN_W:0]   x_f;
  a2h_pkg::stage_t                 prep_nxt;

  logic                            out_tvalid_r;
  logic [a2h_pkg::ANG_W-1:0]       angle_r;
  logic [a2h_pkg::ANG_W-1:0]       angle_nxt;
  logic signed [a2h_pkg::Z_W-1:0]  z_fold;
  logic [a2h_pkg::Z_W-1:0]         z_rnd;
  logic [a2h_pkg::ANG_W:0]         res;

  // pipeline moves as one while the output slot is free or being drained
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // input stage: axis cases, left half-plane fold, scaling
  always_comb begin
    y_in = in_tdata[15:0];
    x_in = in_tdata[31:16];
    y_f  = (a2h_pkg::IN_W+1)'(y_in);
    x_f  = (a2h_pkg::IN_W+1)'(x_in);
    prep_nxt.special    = 1'b0;
    prep_nxt.spec_angle = a2h_pkg::ANG_0;
    prep_nxt.z          = '0;
    if (x_in == '0) begin
      prep_nxt.special = 1'b1;
      if (y_in == '0) begin
        prep_nxt.spec_angle = a2h_pkg::ANG_0;
      end else if (y_in[a2h_pkg::IN_W-1]) begin
        prep_nxt.spec_angle = a2h_pkg::ANG_270;
      end else begin
        prep_nxt.spec_angle = a2h_pkg::ANG_90;
      end
    end else if (y_in == '0) begin
      prep_nxt.special    = 1'b1;
      prep_nxt.spec_angle = x_in[a2h_pkg::IN_W-1] ? a2h_pkg::ANG_180 : a2h_pkg::ANG_0;
    end
    if (x_in[a2h_pkg::IN_W-1]) begin
      x_f        = -x_f;
      y_f        = -y_f;
      prep_nxt.z = a2h_pkg::Z_HALF_TURN;
    end
    prep_nxt.x = a2h_pkg::XY_W'(x_f) <<< a2h_pkg::SCALE_SH;
    prep_nxt.y = a2h_pkg::XY_W'(y_f) <<< a2h_pkg::SCALE_SH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_data[0] <= prep_nxt;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_rot
    a2h_cordic_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .shift    (a2h_pkg::SH_W'(g)),
      .valid_in (s_valid[g]),
      .data_in  (s_data[g]),
      .valid_r  (s_valid[g+1]),
      .data_r   (s_data[g+1])
    );
  end

  // fold into one turn, round half up to 1/128 degree
  always_comb begin
    z_fold = s_data[N].z;
    if (z_fold[a2h_pkg::Z_W-1]) begin
      z_fold = z_fold + a2h_pkg::Z_FULL_TURN;
    end
    z_rnd = a2h_pkg::Z_W'(z_fold) + a2h_pkg::Z_W'(256);
    res   = (a2h_pkg::ANG_W+1)'(z_rnd[a2h_pkg::Z_W-1:9]);
    if (res >= a2h_pkg::OUT_TURN) begin
      res = res - a2h_pkg::OUT_TURN;
    end
    angle_nxt = s_data[N].special ? s_data[N].spec_angle : res[a2h_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= s_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = angle_r;

  // result never reaches a full turn
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (angle_r < a2h_pkg::ANG_W'(360 * 128)))
    else $error("angle out of range");

  // a finished rotation is moved into the output register whenever the pipeline advances
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid[N] && en) |=> out_tvalid_r)
    else $error("result dropped at output stage");

  // vectoring keeps x in the right half-plane
  a_xpos: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid[N] && !s_data[N].special) |-> !s_data[N].x[a2h_pkg::XY_W-1])
    else $error("cordic x went negative");

endmodule

`default_nettype wire
